// File: hw/rtl/rycc_pkg.sv
// Shared types, coefficients and saturation helper for the RGB/YCbCr converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rycc_pkg;

    localparam int unsigned PixW = 8;
    localparam int unsigned SumW = 18;

    typedef logic signed [SumW-1:0] t_sum;
    typedef logic [PixW-1:0]        t_pix;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_INV = 1'b1
    } t_op;

    // Forward coefficients, scaled by 256
    localparam t_pix K_YR  = 8'd77;
    localparam t_pix K_YG  = 8'd150;
    localparam t_pix K_YB  = 8'd29;
    localparam t_pix K_CBR = 8'd44;
    localparam t_pix K_CBG = 8'd87;
    localparam t_pix K_CBB = 8'd131;
    localparam t_pix K_CRR = 8'd131;
    localparam t_pix K_CRG = 8'd110;
    localparam t_pix K_CRB = 8'd21;

    // Inverse coefficients in Q8
    localparam t_sum Q8_CR_TO_R = 18'sd348;
    localparam t_sum Q8_CR_TO_G = 18'sd179;
    localparam t_sum Q8_CB_TO_G = 18'sd84;
    localparam t_sum Q8_CB_TO_B = 18'sd443;

    localparam t_sum CHROMA_OFS = 18'sd128;

    typedef struct packed {
        logic hit;
        t_pix value;
    } t_sat;

    // Clamp a signed sum to 0..255 and flag saturation
    function automatic t_sat sat8(input t_sum v);
        t_sat r;
        r.hit   = 1'b0;
        r.value = v[PixW-1:0];
        if (v < 0) begin
            r.hit   = 1'b1;
            r.value = '0;
        end else if (v > 18'sd255) begin
            r.hit   = 1'b1;
            r.value = '1;
        end
        return r;
    endfunction

    // Truncated product term pix*k/256 as a signed sum operand
    function automatic t_sum fwd_term(input t_pix pix, input t_pix k);
        logic [2*PixW-1:0] p;
        p = pix * k;
        return t_sum'({10'd0, p[2*PixW-1:PixW]});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rgb_ycbcr_color_convert_unit.sv
// Two registers lie between input request accept and result accept: input reg, result reg;
// the result reg loads from the input reg whenever it is empty or its result is accepted.
// Throughput: one pixel per clock unless stalled; back-pressure stalls the result reg first,
// then the input register, so a new request is taken while a result waits.
// Reset (i_rst_n low, synchronous) clears both valid flags; data regs are not reset.
// Depends on rycc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgb_ycbcr_color_convert_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // in_first[7:0], in_second[15:8], in_third[23:16]
    input  wire logic [0:0]  s_axis_tuser,  // op[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // out_first[7:0], out_second[15:8], out_third[23:16]
    output logic [0:0]       m_axis_tuser   // clipped[0]
);

    // input stage
    logic                 r_in_valid;
    rycc_pkg::t_op        r_op;
    rycc_pkg::t_pix       r_a, r_b, r_c;

    // result stage
    logic                 r_out_valid;
    logic [23:0]          r_out_data;
    logic                 r_clip;

    logic                 adv;
    logic [23:0]          n_out_data;
    logic                 n_clip;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;

    always_comb begin
        rycc_pkg::t_sum v_a, v_db, v_dr, v_y;
        rycc_pkg::t_sum s1, s2, s3;
        rycc_pkg::t_sat q1, q2, q3;

        v_a  = rycc_pkg::t_sum'({10'd0, r_a});
        v_db = rycc_pkg::t_sum'({10'd0, r_b}) - rycc_pkg::CHROMA_OFS;
        v_dr = rycc_pkg::t_sum'({10'd0, r_c}) - rycc_pkg::CHROMA_OFS;
        v_y  = v_a <<< 8;

        if (r_op == rycc_pkg::OP_FWD) begin
            s1 = rycc_pkg::fwd_term(r_a, rycc_pkg::K_YR)
               + rycc_pkg::fwd_term(r_b, rycc_pkg::K_YG)
               + rycc_pkg::fwd_term(r_c, rycc_pkg::K_YB);
            s2 = rycc_pkg::CHROMA_OFS
               - rycc_pkg::fwd_term(r_a, rycc_pkg::K_CBR)
               - rycc_pkg::fwd_term(r_b, rycc_pkg::K_CBG)
               + rycc_pkg::fwd_term(r_c, rycc_pkg::K_CBB);
            s3 = rycc_pkg::CHROMA_OFS
               + rycc_pkg::fwd_term(r_a, rycc_pkg::K_CRR)
               - rycc_pkg::fwd_term(r_b, rycc_pkg::K_CRG)
               - rycc_pkg::fwd_term(r_c, rycc_pkg::K_CRB);
        end else begin
            // arithmetic shift gives floor division by 256
            s1 = (v_y + rycc_pkg::Q8_CR_TO_R * v_dr) >>> 8;
            s2 = (v_y - rycc_pkg::Q8_CR_TO_G * v_dr - rycc_pkg::Q8_CB_TO_G * v_db) >>> 8;
            s3 = (v_y + rycc_pkg::Q8_CB_TO_B * v_db) >>> 8;
        end

        q1 = rycc_pkg::sat8(s1);
        q2 = rycc_pkg::sat8(s2);
        q3 = rycc_pkg::sat8(s3);

        n_out_data = {q3.value, q2.value, q1.value};
        n_clip     = q1.hit | q2.hit | q3.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op <= rycc_pkg::t_op'(s_axis_tuser[0]);
            r_a  <= s_axis_tdata[7:0];
            r_b  <= s_axis_tdata[15:8];
            r_c  <= s_axis_tdata[23:16];
        end
        if (adv && r_in_valid) begin
            r_out_data <= n_out_data;
            r_clip     <= n_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_clip;

    // hold: a stalled input request must stay in the input stage
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("input stage dropped a stalled request");

    // advance: a request in the input stage reaches the result stage
    a_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv |=> r_out_valid)
        else $error("request lost between stages");

    // a clipped result has at least one component at a rail
    a_clip_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_clip |->
            (r_out_data[7:0] == 8'd0 || r_out_data[7:0] == 8'd255 ||
             r_out_data[15:8] == 8'd0 || r_out_data[15:8] == 8'd255 ||
             r_out_data[23:16] == 8'd0 || r_out_data[23:16] == 8'd255))
        else $error("clip flag without a saturated component");

    // reset empties the pipeline
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
